// ===== rtl/ehd_pkg.sv =====
// Shared types, constants and the calendar split function for the Easter date block.
// No dependencies; imported by every module under rtl/.
package ehd_pkg;

	localparam int YearW = 14;
	localparam int DoyW  = 9;
	localparam int DayW  = 5;
	localparam int MonW  = 4;
	localparam int KindW = 3;
	localparam int NumKinds = 6;

	localparam logic [YearW-1:0] YearMax = 14'd9999;

	// result kind codes
	localparam logic [KindW-1:0] KindEaster   = 3'd0;
	localparam logic [KindW-1:0] KindCarnBeg  = 3'd1;
	localparam logic [KindW-1:0] KindCarnEnd  = 3'd2;
	localparam logic [KindW-1:0] KindGoodFri  = 3'd3;
	localparam logic [KindW-1:0] KindAscens   = 3'd4;
	localparam logic [KindW-1:0] KindWhitsun  = 3'd5;
	localparam logic [KindW-1:0] KindLast     = KindWhitsun;

	// day offsets from Easter, indexed by kind (two's complement, 9 bits)
	localparam logic [DoyW-1:0] KindOffset [NumKinds] = '{
		9'd0, 9'(-49), 9'(-47), 9'(-2), 9'd39, 9'd49
	};

	// last ordinal day of January..November in a common year
	localparam logic [DoyW-1:0] MonthEnd [11] = '{
		9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [DoyW-1:0] doy;
		logic            leap;
		logic            bad;
	} easter_t;

	typedef struct packed {
		logic [DayW-1:0] day;
		logic [MonW-1:0] month;
	} date_t;

	// ordinal day -> day of month / month; month ends compared in parallel
	function automatic date_t split_date(input logic [DoyW-1:0] doy, input logic leap);
		logic [MonW-1:0] mi;
		logic [DoyW-1:0] start;
		logic [DoyW-1:0] lim;
		date_t           r;
		mi    = '0;
		start = '0;
		for (int j = 0; j < 11; j++) begin
			lim = MonthEnd[j] + ((j >= 1 && leap) ? 9'd1 : 9'd0);
			if (doy > lim) begin
				mi    = MonW'(j + 1);
				start = lim;
			end
		end
		r.day   = DayW'(doy - start);
		r.month = mi + 4'd1;
		return r;
	endfunction

endpackage

// ===== rtl/ehd_computus.sv =====
// Nine-stage pipeline: year -> Easter ordinal day, leap flag, range error.
// Divisions by 100, 19, 30 and 7 use reciprocal multiplies with one correction step;
// (b+8)/25 is a threshold count and /3 is an exact multiply. Depends on ehd_pkg.
module ehd_computus (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ehd_pkg::YearW-1:0] in_year,
	output logic                     res_valid,
	input  logic                     res_ready,
	output ehd_pkg::easter_t         res
);
	import ehd_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [13:0] y_s1, y_s2;
	logic [7:0]  q100_s2;
	logic [9:0]  q19_s2;
	logic        bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7, bad_s8;
	logic        leap_s3, leap_s4, leap_s5, leap_s6, leap_s7, leap_s8;
	logic [4:0]  a_s3, a_s4, a_s5, a_s6, a_s7, a_s8;
	logic [7:0]  b_s3, b_s4;
	logic [6:0]  c_s3, c_s4, c_s5, c_s6;
	logic [6:0]  g_s4;
	logic [1:0]  e_s5, e_s6;
	logic [9:0]  hx_s5, hx_s6;
	logic [5:0]  hq_s6;
	logic [4:0]  h_s7, h_s8;
	logic [6:0]  lx_s7, lx_s8;
	logic [4:0]  lq_s8;
	easter_t     res_s9;

	// whole pipe moves together; stalls only when the tail is held
	assign en       = !v_s9 || res_ready;
	assign in_ready = en;

	// stage 2: quotient estimates (never above the true quotient)
	logic [26:0] p100_est;
	logic [28:0] p19_est;
	assign p100_est = 27'(y_s1) * 27'd5242;
	assign p19_est  = 29'(y_s1) * 29'd27594;

	// stage 3: remainders with one correction, leap flag
	logic [14:0] m100;
	logic [14:0] c_full;
	logic [13:0] m19;
	logic [13:0] a_full;
	logic        c_ov, a_ov;
	logic [6:0]  c_st3;
	logic [7:0]  b_st3;
	logic [4:0]  a_st3;
	assign m100   = 15'(q100_s2) * 15'd100;
	assign c_full = {1'b0, y_s2} - m100;
	assign c_ov   = c_full[7:0] >= 8'd100;
	assign c_st3  = c_ov ? 7'(c_full[7:0] - 8'd100) : c_full[6:0];
	assign b_st3  = q100_s2 + {7'd0, c_ov};
	assign m19    = 14'(q19_s2) * 14'd19;
	assign a_full = y_s2 - m19;
	assign a_ov   = a_full[5:0] >= 6'd19;
	assign a_st3  = a_ov ? 5'(a_full[5:0] - 6'd19) : a_full[4:0];

	// stage 4: f = (b+8)/25 by threshold count, g = (b-f+1)/3
	logic [2:0]  f_st4;
	logic [7:0]  gx;
	logic [15:0] gp;
	assign f_st4 = 3'(b_s3 >= 8'd17) + 3'(b_s3 >= 8'd42) + 3'(b_s3 >= 8'd67)
		+ 3'(b_s3 >= 8'd92) + 3'(b_s3 >= 8'd117) + 3'(b_s3 >= 8'd142);
	assign gx = b_s3 - 8'(f_st4) + 8'd1;
	assign gp = 16'(gx) * 16'd171;

	// stage 5: 19a + b - d - g + 15, reduced mod 30 later
	logic [9:0] hx_st5;
	assign hx_st5 = 10'(a_s4) * 10'd19 + 10'(b_s4) - 10'(b_s4[7:2]) - 10'(g_s4) + 10'd15;

	// stage 6: hx / 30 estimate
	logic [20:0] hqp;
	assign hqp = 21'(hx_s5) * 21'd1092;

	// stage 7: h, and l before mod 7
	logic [9:0] hf;
	logic [4:0] h_st7;
	logic [6:0] lx_st7;
	assign hf     = hx_s6 - 10'(hq_s6) * 10'd30;
	assign h_st7  = (hf >= 10'd30) ? 5'(hf - 10'd30) : hf[4:0];
	assign lx_st7 = 7'd32 + {4'd0, e_s6, 1'b0} + {c_s6[6:2], 1'b0}
		- 7'(h_st7) - 7'(c_s6[1:0]);

	// stage 8: lx / 7 estimate
	logic [12:0] lqp;
	assign lqp = 13'(lx_s7) * 13'd36;

	// stage 9: l, m and Easter's ordinal day (base - 33 + leap)
	logic [6:0] lf;
	logic [2:0] l_st9;
	logic [8:0] mv;
	logic       m_st9;
	logic [8:0] doy_st9;
	assign lf      = lx_s8 - 7'(lq_s8) * 7'd7;
	assign l_st9   = (lf >= 7'd7) ? 3'(lf - 7'd7) : lf[2:0];
	assign mv      = 9'(a_s8) + 9'(h_s8) * 9'd11 + 9'(l_st9) * 9'd22;
	assign m_st9   = mv >= 9'd451;
	assign doy_st9 = 9'(h_s8) + 9'(l_st9) + 9'd81 + 9'(leap_s8) - (m_st9 ? 9'd7 : 9'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= in_year;

			y_s2    <= y_s1;
			q100_s2 <= p100_est[26:19];
			q19_s2  <= p19_est[28:19];
			bad_s2  <= (y_s1 == '0) || (y_s1 > YearMax);

			a_s3    <= a_st3;
			b_s3    <= b_st3;
			c_s3    <= c_st3;
			leap_s3 <= (y_s2[1:0] == 2'd0) && ((c_st3 != 7'd0) || (b_st3[1:0] == 2'd0));
			bad_s3  <= bad_s2;

			a_s4 <= a_s3; b_s4 <= b_s3; c_s4 <= c_s3;
			g_s4 <= gp[15:9];
			leap_s4 <= leap_s3; bad_s4 <= bad_s3;

			a_s5 <= a_s4; e_s5 <= b_s4[1:0]; c_s5 <= c_s4;
			hx_s5 <= hx_st5;
			leap_s5 <= leap_s4; bad_s5 <= bad_s4;

			a_s6 <= a_s5; e_s6 <= e_s5; c_s6 <= c_s5;
			hx_s6 <= hx_s5;
			hq_s6 <= hqp[20:15];
			leap_s6 <= leap_s5; bad_s6 <= bad_s5;

			a_s7 <= a_s6; h_s7 <= h_st7; lx_s7 <= lx_st7;
			leap_s7 <= leap_s6; bad_s7 <= bad_s6;

			a_s8 <= a_s7; h_s8 <= h_s7; lx_s8 <= lx_s7;
			lq_s8 <= lqp[12:8];
			leap_s8 <= leap_s7; bad_s8 <= bad_s7;

			res_s9.doy  <= bad_s8 ? '0 : doy_st9;
			res_s9.leap <= leap_s8 && !bad_s8;
			res_s9.bad  <= bad_s8;
		end
	end

	assign res_valid = v_s9;
	assign res       = res_s9;

	// Easter always falls between March 22 and April 25
	a_easter_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && !res_s9.bad |-> res_s9.doy >= 9'd81 && res_s9.doy <= 9'd116)
		else $error("Easter ordinal day out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && res_s9.bad |-> res_s9.doy == '0 && !res_s9.leap)
		else $error("bad year carries a date");

	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && !res_ready |=> v_s9 && $stable(res_s9))
		else $error("held result changed under stall");

endmodule

// ===== rtl/ehd_emit.sv =====
// Expands one Easter result into six dated beats (Easter and five offsets).
// Holds one job while the output register drains. Depends on ehd_pkg.
module ehd_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ehd_pkg::easter_t         in_res,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ehd_pkg::KindW-1:0] out_kind,
	output logic [ehd_pkg::DayW-1:0]  out_day,
	output logic [ehd_pkg::MonW-1:0]  out_month,
	output logic [ehd_pkg::DoyW-1:0]  out_doy,
	output logic                     out_leap,
	output logic                     out_bad,
	output logic                     out_last
);
	import ehd_pkg::*;

	logic             job_v_q;
	easter_t          job_q;
	logic [KindW-1:0] k_q;
	logic             out_load;
	logic             take;
	logic             job_last;
	logic [DoyW-1:0]  doy_k;
	date_t            date_k;

	logic             out_v_q;
	logic [KindW-1:0] kind_q;
	logic [DayW-1:0]  day_q;
	logic [MonW-1:0]  month_q;
	logic [DoyW-1:0]  doy_q;
	logic             leap_q, bad_q, last_q;

	assign out_load = !out_v_q || out_ready;
	assign job_last = k_q == KindLast;
	assign take     = in_valid && (!job_v_q || (out_load && job_last));
	assign in_ready = take;

	assign doy_k  = job_q.doy + KindOffset[k_q];
	assign date_k = split_date(doy_k, job_q.leap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= job_v_q;
			if (take) begin
				job_v_q <= 1'b1;
				k_q     <= KindEaster;
			end else if (job_v_q && out_load) begin
				if (job_last)
					job_v_q <= 1'b0;
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_q <= in_res;
		if (out_load && job_v_q) begin
			kind_q  <= k_q;
			day_q   <= job_q.bad ? '0 : date_k.day;
			month_q <= job_q.bad ? '0 : date_k.month;
			doy_q   <= job_q.bad ? '0 : doy_k;
			leap_q  <= job_q.leap;
			bad_q   <= job_q.bad;
			last_q  <= job_last;
		end
	end

	assign out_valid = out_v_q;
	assign out_kind  = kind_q;
	assign out_day   = day_q;
	assign out_month = month_q;
	assign out_doy   = doy_q;
	assign out_leap  = leap_q;
	assign out_bad   = bad_q;
	assign out_last  = last_q;

	a_kind_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_ready && !last_q |=> out_v_q && kind_q == $past(kind_q) + 3'd1)
		else $error("beat sequence broken inside a year");

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !job_v_q || k_q == KindLast)
		else $error("new year taken over a running job");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!job_v_q && out_load |=> !out_v_q)
		else $error("beat produced with no job");

	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && bad_q |-> day_q == '0 && month_q == '0 && doy_q == '0 && !leap_q)
		else $error("bad year beat carries a date");

endmodule

// ===== rtl/easter_holy_days_calc_top.sv =====
// A year passes through the nine computus stages, the emit job register and the output
// register before its first beat; the six beats follow one per cycle while the sink is ready.
// The sustained year rate is set by the single result channel, which carries six beats per year.
// A year can be taken every cycle until the 9-stage computus pipe fills.
// Reset (arst_n low) empties the pipe and the output stage; there is no clearing pass.
// Depends on ehd_pkg, ehd_computus, ehd_emit.
module easter_holy_days_calc_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [13:0] year, [15:14] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [4:0] day, [8:5] month, [17:9] day_of_year,
	                              // [18] leap, [19] bad_year, [23:20] zero
	output logic [2:0]  m_tuser,  // [2:0] kind
	output logic        m_tlast
);
	import ehd_pkg::*;

	logic             res_valid;
	logic             res_ready;
	easter_t          res;
	logic [DayW-1:0]  day;
	logic [MonW-1:0]  month;
	logic [DoyW-1:0]  day_of_year;
	logic             leap;
	logic             bad_year;

	ehd_computus u_computus (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_year   (s_tdata[YearW-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	ehd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_day   (day),
		.out_month (month),
		.out_doy   (day_of_year),
		.out_leap  (leap),
		.out_bad   (bad_year),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, bad_year, leap, day_of_year, month, day};

endmodule

// ===== test/easter_holy_days_calc_top_test.sv =====
// Stream testbench for easter_holy_days_calc_top: years in, six holy-day beats out per year.
// Depends on ehd_pkg and the RTL under rtl/; the expected dates are computed here independently.
`timescale 1ns / 1ps

module easter_holy_days_calc_top_test;
	import ehd_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int RandomYears = 100;
	localparam int DirCount    = 20;

	typedef struct {
		logic [KindW-1:0] kind;
		logic [DayW-1:0]  day;
		logic [MonW-1:0]  month;
		logic [DoyW-1:0]  doy;
		logic             leap;
		logic             bad;
		logic             last;
	} holy_date_t;

	class holy_day_board;
		holy_date_t dates_due[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return dates_due.size();
		endfunction

		// Gregorian computus plus the fixed offsets of the dependent feasts
		function void note_year(logic [YearW-1:0] yr);
			int         shift [NumKinds] = '{0, -49, -47, -2, 39, 49};
			int         mlen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			int         y, a, b, c, d, e, f, g, h, i, k, l, m, base;
			int         easter_doy, rem, mi, len;
			bit         bad, leap, found;
			holy_date_t hd;
			y          = yr;
			bad        = (y < 1) || (y > 9999);
			leap       = 0;
			easter_doy = 0;
			if (!bad) begin
				a    = y % 19;
				b    = y / 100;
				c    = y % 100;
				d    = b / 4;
				e    = b % 4;
				f    = (b + 8) / 25;
				g    = (b - f + 1) / 3;
				h    = (19 * a + b - d - g + 15) % 30;
				i    = c / 4;
				k    = c % 4;
				l    = (32 + 2 * e + 2 * i - h - k) % 7;
				m    = (a + 11 * h + 22 * l) / 451;
				base = h + l - 7 * m + 114;
				leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
				easter_doy = 31 + (leap ? 29 : 28) + base % 31 + 1;
				if (base / 31 != 3)
					easter_doy += 31;
			end
			for (int kd = 0; kd < NumKinds; kd++) begin
				hd.kind  = KindW'(kd);
				hd.leap  = leap;
				hd.bad   = bad;
				hd.last  = (hd.kind == KindLast);
				hd.day   = '0;
				hd.month = '0;
				hd.doy   = '0;
				if (!bad) begin
					rem   = easter_doy + shift[kd];
					hd.doy = DoyW'(rem);
					mi    = 0;
					found = 0;
					while (mi < 11 && !found) begin
						len = mlen[mi] + ((mi == 1 && leap) ? 1 : 0);
						if (rem <= len) begin
							found = 1;
						end else begin
							rem -= len;
							mi++;
						end
					end
					hd.day   = DayW'(rem);
					hd.month = MonW'(mi + 1);
				end
				dates_due.push_back(hd);
			end
		endfunction

		// four-state compare so an unknown on the bus counts as a mismatch
		function void match(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(holy_date_t got);
			holy_date_t want;
			if (dates_due.size() == 0) begin
				$error("unexpected beat: kind %0d day %0d month %0d", got.kind, got.day, got.month);
				errors++;
				return;
			end
			want = dates_due.pop_front();
			match("kind", 32'(want.kind), 32'(got.kind));
			match("day", 32'(want.day), 32'(got.day));
			match("month", 32'(want.month), 32'(got.month));
			match("day_of_year", 32'(want.doy), 32'(got.doy));
			match("leap", 32'(want.leap), 32'(got.leap));
			match("bad_year", 32'(want.bad), 32'(got.bad));
			match("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	holy_day_board board;
	holy_date_t    beat_seen;
	int            cycles = 0;
	int            sink_mode = 0;

	// range ends, out-of-range years, century leap rules, earliest and latest Easter
	logic [YearW-1:0] edge_years [DirCount] = '{
		14'd1, 14'd9999, 14'd0, 14'd10000, 14'd16383, 14'd2000, 14'd1900, 14'd2024,
		14'd2019, 14'd1818, 14'd2038, 14'd1981, 14'd1954, 14'd2285, 14'd1600, 14'd8192,
		14'd4, 14'd2100, 14'd1943, 14'd1761
	};

	easter_holy_days_calc_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("easter_holy_days_calc_top test failed");
			$finish;
		end
	end

	// sink stall pattern: mode picked at random from four, mode 0 never stalls
	always @(negedge clk) begin
		if (cycles % 64 == 0)
			sink_mode = $urandom_range(0, 3);
		case (sink_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			2: m_tready <= (cycles % 5 != 0);
			default: m_tready <= ($urandom_range(0, 9) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beat_seen.day   = m_tdata[4:0];
			beat_seen.month = m_tdata[8:5];
			beat_seen.doy   = m_tdata[17:9];
			beat_seen.leap  = m_tdata[18];
			beat_seen.bad   = m_tdata[19];
			beat_seen.kind  = m_tuser;
			beat_seen.last  = m_tlast;
			board.check_beat(beat_seen);
		end
	end

	task automatic push_year(logic [YearW-1:0] yr);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(yr);
		do
			@(posedge clk);
		while (!s_tready);
		board.note_year(yr);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom_range(0, 16383));
		end
	endtask

	task automatic drain();
		idle_cycles(1);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [YearW-1:0] pick_year();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return YearW'($urandom_range(1, 9999));
		else if (roll < 90)
			return '0;
		return YearW'($urandom_range(10000, 16383));
	endfunction

	initial begin
		int burst;
		int gap;
		board = new();
		burst = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// back to back so the computus pipe fills
		for (int j = 0; j < DirCount; j++)
			push_year(edge_years[j]);
		drain();

		for (int n = 0; n < RandomYears; n++) begin
			if (n == RandomYears / 2)
				drain();
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap   = $urandom_range(0, 10);
				if (gap > 0)
					idle_cycles(gap);
			end
			burst--;
			push_year(pick_year());
		end
		drain();
		repeat (20) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("easter_holy_days_calc_top test passed");
		else
			$display("easter_holy_days_calc_top test failed");
		$finish;
	end

endmodule
